### rtl/core/tgr_pkg.sv
package tgr_pkg;

    // Geometry of the text area and of one glyph.
    localparam int LINE_WIDTH   = 128;
    localparam int GLYPH_ROWS   = 8;
    localparam int GLYPH_COLS   = 5;
    localparam int GLYPH_COUNT  = 95;

    localparam logic [7:0] GLYPH_FIRST  = 8'd32;
    localparam logic [7:0] GLYPH_LAST   = 8'd126;
    localparam logic [7:0] NEWLINE_CODE = 8'd10;
    localparam logic [7:0] CHAR_ADVANCE = 8'd6;
    localparam logic [9:0] LINE_ADVANCE = 10'd10;
    localparam logic [9:0] ROW_MAX      = 10'd1023;
    localparam logic [7:0] WRAP_LIMIT   = 8'(LINE_WIDTH - 6);

    localparam logic [2:0] LAST_ROW = 3'(GLYPH_ROWS - 1);
    localparam logic [2:0] LAST_COL = 3'(GLYPH_COLS - 1);

    // Configuration register indexes.
    localparam int CFG_INDEX_W = 8;
    localparam logic [CFG_INDEX_W-1:0] CFG_ORIGIN_X   = 8'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_ORIGIN_Y   = 8'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_FORE_COLOR = 8'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_BACK_COLOR = 8'd3;

    localparam logic [6:0]  ORIGIN_X_RESET   = 7'd2;
    localparam logic [6:0]  ORIGIN_Y_RESET   = 7'd10;
    localparam logic [15:0] FORE_COLOR_RESET = 16'hFFFF;
    localparam logic [15:0] BACK_COLOR_RESET = 16'h0000;

    // Job queue between the front and the back.
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // One glyph to draw: font entry and top-left corner on screen.
    typedef struct packed {
        logic [6:0] glyph;
        logic [7:0] col;
        logic [9:0] row;
    } job_t;

    // Column bytes of the font, printable ASCII from space upward.
    localparam logic [7:0] FONT_ROM [GLYPH_COUNT][GLYPH_COLS] = '{
        '{8'd0, 8'd0, 8'd0, 8'd0, 8'd0},         '{8'd0, 8'd0, 8'd95, 8'd0, 8'd0},
        '{8'd0, 8'd7, 8'd0, 8'd7, 8'd0},         '{8'd20, 8'd127, 8'd20, 8'd127, 8'd20},
        '{8'd36, 8'd42, 8'd127, 8'd42, 8'd18},   '{8'd35, 8'd19, 8'd8, 8'd100, 8'd98},
        '{8'd54, 8'd73, 8'd85, 8'd34, 8'd80},    '{8'd0, 8'd5, 8'd3, 8'd0, 8'd0},
        '{8'd0, 8'd28, 8'd34, 8'd65, 8'd0},      '{8'd0, 8'd65, 8'd34, 8'd28, 8'd0},
        '{8'd20, 8'd8, 8'd62, 8'd8, 8'd20},      '{8'd8, 8'd8, 8'd62, 8'd8, 8'd8},
        '{8'd0, 8'd80, 8'd48, 8'd0, 8'd0},       '{8'd8, 8'd8, 8'd8, 8'd8, 8'd8},
        '{8'd0, 8'd96, 8'd96, 8'd0, 8'd0},       '{8'd32, 8'd16, 8'd8, 8'd4, 8'd2},
        '{8'd62, 8'd81, 8'd73, 8'd69, 8'd62},    '{8'd0, 8'd66, 8'd127, 8'd64, 8'd0},
        '{8'd66, 8'd97, 8'd81, 8'd73, 8'd70},    '{8'd33, 8'd65, 8'd69, 8'd75, 8'd49},
        '{8'd24, 8'd20, 8'd18, 8'd127, 8'd16},   '{8'd39, 8'd69, 8'd69, 8'd69, 8'd57},
        '{8'd60, 8'd74, 8'd73, 8'd73, 8'd48},    '{8'd1, 8'd113, 8'd9, 8'd5, 8'd3},
        '{8'd54, 8'd73, 8'd73, 8'd73, 8'd54},    '{8'd6, 8'd73, 8'd73, 8'd41, 8'd30},
        '{8'd0, 8'd54, 8'd54, 8'd0, 8'd0},       '{8'd0, 8'd86, 8'd54, 8'd0, 8'd0},
        '{8'd8, 8'd20, 8'd34, 8'd65, 8'd0},      '{8'd20, 8'd20, 8'd20, 8'd20, 8'd20},
        '{8'd0, 8'd65, 8'd34, 8'd20, 8'd8},      '{8'd2, 8'd1, 8'd81, 8'd9, 8'd6},
        '{8'd50, 8'd73, 8'd121, 8'd65, 8'd62},   '{8'd126, 8'd17, 8'd17, 8'd17, 8'd126},
        '{8'd127, 8'd73, 8'd73, 8'd73, 8'd54},   '{8'd62, 8'd65, 8'd65, 8'd65, 8'd34},
        '{8'd127, 8'd65, 8'd65, 8'd34, 8'd28},   '{8'd127, 8'd73, 8'd73, 8'd73, 8'd65},
        '{8'd127, 8'd9, 8'd9, 8'd9, 8'd1},       '{8'd62, 8'd65, 8'd73, 8'd73, 8'd122},
        '{8'd127, 8'd8, 8'd8, 8'd8, 8'd127},     '{8'd0, 8'd65, 8'd127, 8'd65, 8'd0},
        '{8'd32, 8'd64, 8'd65, 8'd63, 8'd1},     '{8'd127, 8'd8, 8'd20, 8'd34, 8'd65},
        '{8'd127, 8'd64, 8'd64, 8'd64, 8'd64},   '{8'd127, 8'd2, 8'd12, 8'd2, 8'd127},
        '{8'd127, 8'd4, 8'd8, 8'd16, 8'd127},    '{8'd62, 8'd65, 8'd65, 8'd65, 8'd62},
        '{8'd127, 8'd9, 8'd9, 8'd9, 8'd6},       '{8'd62, 8'd65, 8'd81, 8'd33, 8'd94},
        '{8'd127, 8'd9, 8'd25, 8'd41, 8'd70},    '{8'd70, 8'd73, 8'd73, 8'd73, 8'd49},
        '{8'd1, 8'd1, 8'd127, 8'd1, 8'd1},       '{8'd63, 8'd64, 8'd64, 8'd64, 8'd63},
        '{8'd31, 8'd32, 8'd64, 8'd32, 8'd31},    '{8'd63, 8'd64, 8'd56, 8'd64, 8'd63},
        '{8'd99, 8'd20, 8'd8, 8'd20, 8'd99},     '{8'd7, 8'd8, 8'd112, 8'd8, 8'd7},
        '{8'd97, 8'd81, 8'd73, 8'd69, 8'd67},    '{8'd0, 8'd127, 8'd65, 8'd65, 8'd0},
        '{8'd2, 8'd4, 8'd8, 8'd16, 8'd32},       '{8'd0, 8'd65, 8'd65, 8'd127, 8'd0},
        '{8'd4, 8'd2, 8'd1, 8'd2, 8'd4},         '{8'd64, 8'd64, 8'd64, 8'd64, 8'd64},
        '{8'd0, 8'd1, 8'd2, 8'd4, 8'd0},         '{8'd32, 8'd84, 8'd84, 8'd84, 8'd120},
        '{8'd127, 8'd72, 8'd68, 8'd68, 8'd56},   '{8'd56, 8'd68, 8'd68, 8'd68, 8'd32},
        '{8'd56, 8'd68, 8'd68, 8'd72, 8'd127},   '{8'd56, 8'd84, 8'd84, 8'd84, 8'd24},
        '{8'd8, 8'd126, 8'd9, 8'd1, 8'd2},       '{8'd12, 8'd82, 8'd82, 8'd82, 8'd62},
        '{8'd127, 8'd8, 8'd4, 8'd4, 8'd120},     '{8'd0, 8'd68, 8'd125, 8'd64, 8'd0},
        '{8'd32, 8'd64, 8'd68, 8'd61, 8'd0},     '{8'd127, 8'd16, 8'd40, 8'd68, 8'd0},
        '{8'd0, 8'd65, 8'd127, 8'd64, 8'd0},     '{8'd124, 8'd4, 8'd24, 8'd4, 8'd120},
        '{8'd124, 8'd8, 8'd4, 8'd4, 8'd120},     '{8'd56, 8'd68, 8'd68, 8'd68, 8'd56},
        '{8'd124, 8'd20, 8'd20, 8'd20, 8'd8},    '{8'd8, 8'd20, 8'd20, 8'd24, 8'd124},
        '{8'd124, 8'd8, 8'd4, 8'd4, 8'd8},       '{8'd72, 8'd84, 8'd84, 8'd84, 8'd32},
        '{8'd4, 8'd63, 8'd68, 8'd64, 8'd32},     '{8'd60, 8'd64, 8'd64, 8'd32, 8'd124},
        '{8'd28, 8'd32, 8'd64, 8'd32, 8'd28},    '{8'd60, 8'd64, 8'd48, 8'd64, 8'd60},
        '{8'd68, 8'd40, 8'd16, 8'd40, 8'd68},    '{8'd12, 8'd80, 8'd80, 8'd80, 8'd60},
        '{8'd68, 8'd100, 8'd84, 8'd76, 8'd68},   '{8'd8, 8'd54, 8'd65, 8'd65, 8'd0},
        '{8'd0, 8'd0, 8'd119, 8'd0, 8'd0},       '{8'd0, 8'd65, 8'd65, 8'd54, 8'd8},
        '{8'd8, 8'd12, 8'd6, 8'd3, 8'd1}
    };

    // Row plus a line step, clamped to the last screen row.
    function automatic logic [9:0] sat_row_add(input logic [9:0] row, input logic [9:0] step);
        logic [10:0] sum;
        sum = {1'b0, row} + {1'b0, step};
        sat_row_add = sum[10] ? ROW_MAX : sum[9:0];
    endfunction

endpackage

### rtl/core/tgr_front.sv
module tgr_front (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [7:0]         char_code,
    input  logic               start_of_text,
    input  logic [6:0]         origin_x,
    input  logic [6:0]         origin_y,
    input  logic               queue_full,
    output logic               job_push,
    output tgr_pkg::job_t      job
);

    logic [7:0] cursor_col_reg;
    logic [7:0] cursor_col_next;
    logic [9:0] cursor_row_reg;
    logic [9:0] cursor_row_next;

    logic       accept;
    logic [7:0] col_start;
    logic [9:0] row_start;
    logic [9:0] row_down;
    logic       is_newline;
    logic       is_printable;
    logic       wrap;
    logic [7:0] col_draw;
    logic [9:0] row_draw;
    logic [7:0] glyph_offset;

    assign in_ready = !queue_full;
    assign accept   = in_valid && in_ready;

    always_comb
    begin
        col_start    = start_of_text ? {1'b0, origin_x} : cursor_col_reg;
        row_start    = start_of_text ? {3'b000, origin_y} : cursor_row_reg;
        row_down     = tgr_pkg::sat_row_add(row_start, tgr_pkg::LINE_ADVANCE);
        is_newline   = (char_code == tgr_pkg::NEWLINE_CODE);
        is_printable = (char_code >= tgr_pkg::GLYPH_FIRST) &&
                       (char_code <= tgr_pkg::GLYPH_LAST);
        wrap         = (col_start > tgr_pkg::WRAP_LIMIT);
        col_draw     = wrap ? {1'b0, origin_x} : col_start;
        row_draw     = wrap ? row_down : row_start;
        glyph_offset = char_code - tgr_pkg::GLYPH_FIRST;

        cursor_col_next = cursor_col_reg;
        cursor_row_next = cursor_row_reg;
        if (accept)
        begin
            if (is_newline)
            begin
                cursor_col_next = {1'b0, origin_x};
                cursor_row_next = row_down;
            end
            else
            begin
                cursor_col_next = col_draw + tgr_pkg::CHAR_ADVANCE;
                cursor_row_next = row_draw;
            end
        end

        job_push  = accept && !is_newline && is_printable;
        job.glyph = glyph_offset[6:0];
        job.col   = col_draw;
        job.row   = row_draw;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cursor_col_reg <= 8'd0;
            cursor_row_reg <= 10'd0;
        end
        else
        begin
            cursor_col_reg <= cursor_col_next;
            cursor_row_reg <= cursor_row_next;
        end
    end

endmodule

### rtl/core/tgr_queue.sv
module tgr_queue (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  tgr_pkg::job_t  push_job,
    input  logic           pop,
    output tgr_pkg::job_t  head_job,
    output logic           empty,
    output logic           full
);

    tgr_pkg::job_t                       entries [tgr_pkg::QUEUE_DEPTH];
    logic [tgr_pkg::QPTR_W-1:0]          wr_ptr_reg;
    logic [tgr_pkg::QPTR_W-1:0]          wr_ptr_next;
    logic [tgr_pkg::QPTR_W-1:0]          rd_ptr_reg;
    logic [tgr_pkg::QPTR_W-1:0]          rd_ptr_next;
    logic [tgr_pkg::QCNT_W-1:0]          count_reg;
    logic [tgr_pkg::QCNT_W-1:0]          count_next;

    localparam logic [tgr_pkg::QPTR_W-1:0] PTR_LAST = tgr_pkg::QPTR_W'(tgr_pkg::QUEUE_DEPTH - 1);
    localparam logic [tgr_pkg::QCNT_W-1:0] CNT_FULL = tgr_pkg::QCNT_W'(tgr_pkg::QUEUE_DEPTH);

    assign empty    = (count_reg == '0);
    assign full     = (count_reg == CNT_FULL);
    assign head_job = entries[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entries[wr_ptr_reg] <= push_job;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

### rtl/core/tgr_back.sv
module tgr_back (
    input  logic           clk,
    input  logic           rst_n,
    input  tgr_pkg::job_t  head_job,
    input  logic           queue_empty,
    output logic           job_pop,
    input  logic [15:0]    fore_color,
    input  logic [15:0]    back_color,
    output logic           out_valid,
    input  logic           out_ready,
    output logic [7:0]     pixel_x,
    output logic [9:0]     pixel_y,
    output logic [15:0]    pixel_color,
    output logic           last_pixel
);

    logic          busy_reg;
    logic          busy_next;
    tgr_pkg::job_t job_reg;
    logic [7:0]    glyph_reg [tgr_pkg::GLYPH_COLS];
    logic [2:0]    row_idx_reg;
    logic [2:0]    row_idx_next;
    logic [2:0]    col_idx_reg;
    logic [2:0]    col_idx_next;

    logic          out_valid_reg;
    logic [7:0]    pixel_x_reg;
    logic [9:0]    pixel_y_reg;
    logic [15:0]   pixel_color_reg;
    logic          last_pixel_reg;

    logic          advance;
    logic          emit;
    logic          at_last;
    logic [7:0]    col_byte;
    logic          ink_bit;

    assign advance = !out_valid_reg || out_ready;
    assign emit    = busy_reg && advance;
    assign at_last = (row_idx_reg == tgr_pkg::LAST_ROW) && (col_idx_reg == tgr_pkg::LAST_COL);
    // The next glyph loads in the same cycle as the last pixel of the current one.
    assign job_pop = !queue_empty && (!busy_reg || (emit && at_last));

    assign col_byte = glyph_reg[col_idx_reg];
    assign ink_bit  = col_byte[row_idx_reg];

    always_comb
    begin
        busy_next    = busy_reg;
        row_idx_next = row_idx_reg;
        col_idx_next = col_idx_reg;
        if (job_pop)
        begin
            busy_next    = 1'b1;
            row_idx_next = 3'd0;
            col_idx_next = 3'd0;
        end
        else if (emit)
        begin
            if (at_last)
            begin
                busy_next = 1'b0;
            end
            else if (col_idx_reg == tgr_pkg::LAST_COL)
            begin
                col_idx_next = 3'd0;
                row_idx_next = row_idx_reg + 3'd1;
            end
            else
            begin
                col_idx_next = col_idx_reg + 3'd1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (job_pop)
        begin
            job_reg <= head_job;
            for (int k = 0; k < tgr_pkg::GLYPH_COLS; k++)
            begin
                glyph_reg[k] <= tgr_pkg::FONT_ROM[head_job.glyph][k];
            end
        end
        if (emit)
        begin
            pixel_x_reg     <= job_reg.col + {5'd0, col_idx_reg};
            pixel_y_reg     <= tgr_pkg::sat_row_add(job_reg.row, {7'd0, row_idx_reg});
            pixel_color_reg <= ink_bit ? fore_color : back_color;
            last_pixel_reg  <= at_last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            row_idx_reg   <= 3'd0;
            col_idx_reg   <= 3'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            busy_reg    <= busy_next;
            row_idx_reg <= row_idx_next;
            col_idx_reg <= col_idx_next;
            if (advance)
            begin
                out_valid_reg <= busy_reg;
            end
        end
    end

    assign out_valid   = out_valid_reg;
    assign pixel_x     = pixel_x_reg;
    assign pixel_y     = pixel_y_reg;
    assign pixel_color = pixel_color_reg;
    assign last_pixel  = last_pixel_reg;

endmodule

### rtl/core/text_glyph_pixel_renderer.sv
// Channel   Direction  Handshake            Payload
// input     in         in_valid/in_ready    char_code[7:0], start_of_text
// output    out        out_valid/out_ready  pixel_x[7:0], pixel_y[9:0], pixel_color[15:0],
//                                           last_pixel
// config    in         cfg_valid/cfg_ready  cfg_index[7:0], cfg_data[15:0]
//
// A printable character is drawn as 40 pixels: the pixel unit emits one pixel per cycle
// while out_ready allows, and the next queued glyph is loaded while the last pixel of the
// current one goes out. Newlines and unprintable characters only move the cursor.
// The front takes a character every cycle until two glyphs wait in the job queue.
// Reset clears the cursor to column 0, row 0 and loads the register reset values.
// An output stall holds the pixel register and fills the queue before input stalls.
module text_glyph_pixel_renderer (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  char_code,
    input  logic        start_of_text,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [7:0]  pixel_x,
    output logic [9:0]  pixel_y,
    output logic [15:0] pixel_color,
    output logic        last_pixel,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [7:0]  cfg_index,
    input  logic [15:0] cfg_data
);

    logic [6:0]    origin_x_reg;
    logic [6:0]    origin_y_reg;
    logic [15:0]   fore_color_reg;
    logic [15:0]   back_color_reg;

    logic          job_push;
    logic          job_pop;
    logic          queue_empty;
    logic          queue_full;
    tgr_pkg::job_t push_job;
    tgr_pkg::job_t head_job;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            origin_x_reg   <= tgr_pkg::ORIGIN_X_RESET;
            origin_y_reg   <= tgr_pkg::ORIGIN_Y_RESET;
            fore_color_reg <= tgr_pkg::FORE_COLOR_RESET;
            back_color_reg <= tgr_pkg::BACK_COLOR_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                tgr_pkg::CFG_ORIGIN_X:   origin_x_reg   <= cfg_data[6:0];
                tgr_pkg::CFG_ORIGIN_Y:   origin_y_reg   <= cfg_data[6:0];
                tgr_pkg::CFG_FORE_COLOR: fore_color_reg <= cfg_data;
                tgr_pkg::CFG_BACK_COLOR: back_color_reg <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    tgr_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .char_code     (char_code),
        .start_of_text (start_of_text),
        .origin_x      (origin_x_reg),
        .origin_y      (origin_y_reg),
        .queue_full    (queue_full),
        .job_push      (job_push),
        .job           (push_job)
    );

    tgr_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (job_push),
        .push_job (push_job),
        .pop      (job_pop),
        .head_job (head_job),
        .empty    (queue_empty),
        .full     (queue_full)
    );

    tgr_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .head_job    (head_job),
        .queue_empty (queue_empty),
        .job_pop     (job_pop),
        .fore_color  (fore_color_reg),
        .back_color  (back_color_reg),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .pixel_x     (pixel_x),
        .pixel_y     (pixel_y),
        .pixel_color (pixel_color),
        .last_pixel  (last_pixel)
    );

endmodule
